/* hw/rtl/kruskal_spanning_tree_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef KRUSKAL_SPANNING_TREE_MACROS_SVH
`define KRUSKAL_SPANNING_TREE_MACROS_SVH

// same-cycle implication
`define KST_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define KST_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/kst_pkg.sv */
// ----------------------------------------------------------------------------
// kst_pkg
// Sizes, edge record, chain control and sequencer states.
// ----------------------------------------------------------------------------
package kst_pkg;

	localparam int MAX_VERTICES = 64;
	localparam int MAX_EDGES    = 256;
	localparam int WEIGHT_BITS  = 16;
	localparam int VERTEX_BITS  = 7;
	localparam int VIDX_BITS    = $clog2(MAX_VERTICES);
	localparam int ECNT_BITS    = $clog2(MAX_EDGES + 1);
	localparam int CNT_BITS     = $clog2(MAX_EDGES + MAX_VERTICES + 1);
	localparam int KEY_BITS     = WEIGHT_BITS + 2 * VERTEX_BITS;

	typedef struct packed {
		logic [VERTEX_BITS-1:0]        from_v;
		logic [VERTEX_BITS-1:0]        to_v;
		logic signed [WEIGHT_BITS-1:0] weight;
	} edge_t;

	typedef enum logic [1:0] {
		CM_HOLD,
		CM_INSERT,
		CM_SHIFT,
		CM_CLEAR
	} chain_mode_t;

	typedef struct packed {
		chain_mode_t mode;
		logic        in_valid;
	} chain_ctrl_t;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_FLUSH,
		ST_INIT,
		ST_NEXT,
		ST_FIND_REQ,
		ST_FIND_CHK,
		ST_PUSH,
		ST_FINAL,
		ST_CLEAR
	} state_t;

	// order by signed weight, then from, then to
	function automatic logic [KEY_BITS-1:0] edge_key(edge_t e);
		edge_key = {~e.weight[WEIGHT_BITS-1], e.weight[WEIGHT_BITS-2:0], e.from_v, e.to_v};
	endfunction

	function automatic logic edge_less(edge_t a, edge_t b);
		edge_less = edge_key(a) < edge_key(b);
	endfunction

endpackage

/* hw/rtl/kst_ifs.sv */
// ----------------------------------------------------------------------------
// kst channel interfaces
// Valid/ready channels for loaded edges and for tree edges.
// ----------------------------------------------------------------------------
interface kst_edge_if import kst_pkg::*; ();
	logic                          valid;
	logic                          ready;
	logic [VERTEX_BITS-1:0]        edge_from;
	logic [VERTEX_BITS-1:0]        edge_to;
	logic signed [WEIGHT_BITS-1:0] edge_weight;
	logic                          edge_last;

	modport source (output valid, edge_from, edge_to, edge_weight, edge_last, input ready);
	modport sink (input valid, edge_from, edge_to, edge_weight, edge_last, output ready);
endinterface

interface kst_tree_if import kst_pkg::*; ();
	logic                          valid;
	logic                          ready;
	logic [VERTEX_BITS-1:0]        tree_from;
	logic [VERTEX_BITS-1:0]        tree_to;
	logic signed [WEIGHT_BITS-1:0] tree_weight;
	logic                          tree_last;
	logic                          edges_overflow;

	modport source (output valid, tree_from, tree_to, tree_weight, tree_last, edges_overflow,
		input ready);
	modport sink (input valid, tree_from, tree_to, tree_weight, tree_last, edges_overflow,
		output ready);
endinterface

/* hw/rtl/kst_cell.sv */
// ----------------------------------------------------------------------------
// kst_cell
// One sorter cell: keeps the smaller edge, passes the larger to the right.
// ----------------------------------------------------------------------------
module kst_cell import kst_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  chain_ctrl_t ctrl,
	input  logic        in_v,
	input  edge_t       in_e,
	input  logic        nb_v,
	input  edge_t       nb_e,
	output logic        held_v,
	output edge_t       held_e,
	output logic        carry_v,
	output edge_t       carry_e
);

	logic  held_v_q, carry_v_q;
	edge_t held_e_q, carry_e_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_v_q  <= 1'b0;
			carry_v_q <= 1'b0;
		end else begin
			unique case (ctrl.mode)
				CM_INSERT: begin
					carry_v_q <= in_v & held_v_q;
					if (in_v) begin
						if (!held_v_q) begin
							held_v_q <= 1'b1;
							held_e_q <= in_e;
						end else if (edge_less(in_e, held_e_q)) begin
							held_e_q  <= in_e;
							carry_e_q <= held_e_q;
						end else begin
							carry_e_q <= in_e;
						end
					end
				end
				CM_SHIFT: begin
					held_v_q  <= nb_v;
					held_e_q  <= nb_e;
					carry_v_q <= 1'b0;
				end
				CM_CLEAR: begin
					held_v_q  <= 1'b0;
					carry_v_q <= 1'b0;
				end
				CM_HOLD: begin
				end
				default: begin
				end
			endcase
		end
	end

	assign held_v  = held_v_q;
	assign held_e  = held_e_q;
	assign carry_v = carry_v_q;
	assign carry_e = carry_e_q;

endmodule

/* hw/rtl/kst_chain.sv */
// ----------------------------------------------------------------------------
// kst_chain
// Row of sorter cells; the smallest edge sits at the head, shifts out on pop.
// ----------------------------------------------------------------------------
module kst_chain import kst_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  chain_ctrl_t ctrl,
	input  edge_t       in_e,
	output logic        head_v,
	output edge_t       head_e
);

	logic  hv [MAX_EDGES];
	edge_t he [MAX_EDGES];
	logic  cv [MAX_EDGES];
	edge_t ce [MAX_EDGES];

	for (genvar i = 0; i < MAX_EDGES; i++) begin : g_cell
		logic  c_in_v, c_nb_v;
		edge_t c_in_e, c_nb_e;

		if (i == 0) begin : g_first
			assign c_in_v = ctrl.in_valid;
			assign c_in_e = in_e;
		end else begin : g_mid
			assign c_in_v = cv[i-1];
			assign c_in_e = ce[i-1];
		end

		if (i == MAX_EDGES - 1) begin : g_end
			assign c_nb_v = 1'b0;
			assign c_nb_e = '0;
		end else begin : g_inner
			assign c_nb_v = hv[i+1];
			assign c_nb_e = he[i+1];
		end

		kst_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctrl    (ctrl),
			.in_v    (c_in_v),
			.in_e    (c_in_e),
			.nb_v    (c_nb_v),
			.nb_e    (c_nb_e),
			.held_v  (hv[i]),
			.held_e  (he[i]),
			.carry_v (cv[i]),
			.carry_e (ce[i])
		);
	end

	assign head_v = hv[0];
	assign head_e = he[0];

endmodule

/* hw/rtl/kruskal_spanning_tree.sv */
// Load: one edge word per cycle; the first MAX_EDGES are inserted into the sorter cell row
// as they arrive. After the last word the row settles and the parent memory is set up;
// then each sorted edge leaves the head, and one whose endpoints are in range walks the
// find path of each endpoint (root included) and, if accepted, is pushed to the output.
// After the scan: mark the last word, then clear the row; output stalls hold the scan.
// Reset (arst_n low, async): row empty, counters zero, vertex_count 64, output idle.
// ----------------------------------------------------------------------------
// kruskal_spanning_tree
// Minimum spanning tree: systolic sort of edges, then union-find over a memory.
// ----------------------------------------------------------------------------
`include "kruskal_spanning_tree_macros.svh"

module kruskal_spanning_tree import kst_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [VERTEX_BITS-1:0] cfg_wdata,
	kst_edge_if.sink               edge_in,
	kst_tree_if.source             tree_out
);

	state_t state_q, state_d;

	logic [VERTEX_BITS-1:0] vc_q, nv, acc_q;
	logic [ECNT_BITS-1:0]   ecnt_q;
	logic                   ovf_q;
	logic [CNT_BITS-1:0]    cnt_q;

	edge_t                  cur_e_q, hold_e_q, out_e_q;
	logic                   hold_v_q, out_v_q, out_last_q, out_ovf_q;
	logic [VIDX_BITS-1:0]   cur_v_q, root_a_q, pm_rdata_q;
	logic                   phase_q;

	logic [VIDX_BITS-1:0]   parent_mem [MAX_VERTICES];
	logic                   pm_we;
	logic [VIDX_BITS-1:0]   pm_waddr, pm_wdata;

	chain_ctrl_t ctrl;
	logic        head_v;
	edge_t       head_e, in_e;
	logic        in_fire, out_free, stop, head_ok, root_hit, link, out_load;

	assign nv = (vc_q == '0) ? VERTEX_BITS'(1) :
		(vc_q > VERTEX_BITS'(MAX_VERTICES)) ? VERTEX_BITS'(MAX_VERTICES) : vc_q;

	assign in_fire  = edge_in.valid & edge_in.ready;
	assign out_free = !out_v_q || tree_out.ready;
	assign stop     = ((acc_q + VERTEX_BITS'(1)) >= nv) || !head_v;
	assign head_ok  = (head_e.from_v != '0) && (head_e.from_v <= nv) &&
		(head_e.to_v != '0) && (head_e.to_v <= nv);
	assign root_hit = pm_rdata_q == cur_v_q;
	assign link     = (state_q == ST_FIND_CHK) && root_hit && phase_q && (root_a_q != cur_v_q);
	assign out_load = (state_q == ST_PUSH || state_q == ST_FINAL) && out_free && hold_v_q;

	assign in_e.from_v = edge_in.edge_from;
	assign in_e.to_v   = edge_in.edge_to;
	assign in_e.weight = edge_in.edge_weight;

	kst_chain u_chain (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.in_e   (in_e),
		.head_v (head_v),
		.head_e (head_e)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD:     if (in_fire && edge_in.edge_last) state_d = ST_FLUSH;
			ST_FLUSH:    if (cnt_q == CNT_BITS'(MAX_EDGES - 1)) state_d = ST_INIT;
			ST_INIT:     if (cnt_q == CNT_BITS'(MAX_VERTICES - 1)) state_d = ST_NEXT;
			ST_NEXT: begin
				if (stop) state_d = ST_FINAL;
				else if (head_ok) state_d = ST_FIND_REQ;
			end
			ST_FIND_REQ: state_d = ST_FIND_CHK;
			ST_FIND_CHK: begin
				if (!root_hit || !phase_q) state_d = ST_FIND_REQ;
				else if (root_a_q == cur_v_q) state_d = ST_NEXT;
				else state_d = ST_PUSH;
			end
			ST_PUSH:     if (out_free) state_d = ST_NEXT;
			ST_FINAL:    if (out_free) state_d = ST_CLEAR;
			ST_CLEAR:    state_d = ST_LOAD;
			default:     state_d = ST_LOAD;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		edge_in.ready = 1'b0;
		ctrl.mode     = CM_HOLD;
		ctrl.in_valid = 1'b0;
		pm_we         = 1'b0;
		pm_waddr      = root_a_q;
		pm_wdata      = cur_v_q;
		unique case (state_q)
			ST_LOAD: begin
				edge_in.ready = 1'b1;
				ctrl.mode     = CM_INSERT;
				ctrl.in_valid = in_fire && (ecnt_q < ECNT_BITS'(MAX_EDGES));
			end
			ST_FLUSH: ctrl.mode = CM_INSERT;
			ST_INIT: begin
				pm_we    = 1'b1;
				pm_waddr = cnt_q[VIDX_BITS-1:0];
				pm_wdata = cnt_q[VIDX_BITS-1:0];
			end
			ST_NEXT:     if (!stop) ctrl.mode = CM_SHIFT;
			ST_FIND_CHK: pm_we = link;
			ST_CLEAR:    ctrl.mode = CM_CLEAR;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (pm_we) parent_mem[pm_waddr] <= pm_wdata;
		pm_rdata_q <= parent_mem[cur_v_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_LOAD;
			vc_q       <= VERTEX_BITS'(64);
			ecnt_q     <= '0;
			ovf_q      <= 1'b0;
			acc_q      <= '0;
			cnt_q      <= '0;
			hold_v_q   <= 1'b0;
			out_v_q    <= 1'b0;
			phase_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= (state_d != state_q) ? '0 : cnt_q + CNT_BITS'(1);
			if (cfg_we) vc_q <= cfg_wdata;
			if (out_v_q && tree_out.ready && !out_load) out_v_q <= 1'b0;

			unique case (state_q)
				ST_LOAD: begin
					if (in_fire) begin
						if (ecnt_q < ECNT_BITS'(MAX_EDGES)) ecnt_q <= ecnt_q + ECNT_BITS'(1);
						else ovf_q <= 1'b1;
					end
				end
				ST_NEXT: begin
					if (!stop) begin
						cur_e_q <= head_e;
						cur_v_q <= VIDX_BITS'(head_e.from_v - VERTEX_BITS'(1));
						phase_q <= 1'b0;
					end
				end
				ST_FIND_CHK: begin
					if (!root_hit) begin
						cur_v_q <= pm_rdata_q;
					end else if (!phase_q) begin
						root_a_q <= cur_v_q;
						cur_v_q  <= VIDX_BITS'(cur_e_q.to_v - VERTEX_BITS'(1));
						phase_q  <= 1'b1;
					end else if (link) begin
						acc_q <= acc_q + VERTEX_BITS'(1);
					end
				end
				ST_PUSH: begin
					if (out_free) begin
						if (hold_v_q) begin
							out_v_q    <= 1'b1;
							out_e_q    <= hold_e_q;
							out_last_q <= 1'b0;
							out_ovf_q  <= ovf_q;
						end
						hold_e_q <= cur_e_q;
						hold_v_q <= 1'b1;
					end
				end
				ST_FINAL: begin
					if (out_free) begin
						if (hold_v_q) begin
							out_v_q    <= 1'b1;
							out_e_q    <= hold_e_q;
							out_last_q <= 1'b1;
							out_ovf_q  <= ovf_q;
						end
						hold_v_q <= 1'b0;
					end
				end
				ST_CLEAR: begin
					ecnt_q <= '0;
					ovf_q  <= 1'b0;
					acc_q  <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	assign tree_out.valid          = out_v_q;
	assign tree_out.tree_from      = out_e_q.from_v;
	assign tree_out.tree_to        = out_e_q.to_v;
	assign tree_out.tree_weight    = out_e_q.weight;
	assign tree_out.tree_last      = out_last_q;
	assign tree_out.edges_overflow = out_ovf_q;

	`KST_ASSERT_NOW(a_acc_bound, state_q != ST_LOAD, acc_q < nv, "accepted count past limit")
	`KST_ASSERT_NOW(a_no_overwrite, out_v_q && !tree_out.ready, !out_load, "output word overwritten")
	`KST_ASSERT_NEXT(a_final_last, state_q == ST_FINAL && out_load, out_v_q && out_last_q, "final word not marked last")
	`KST_ASSERT_NEXT(a_link_count, link, acc_q == $past(acc_q) + VERTEX_BITS'(1), "link without count")

endmodule

/* sim/tb_kruskal_spanning_tree.sv */
// ----------------------------------------------------------------------------
// tb_kruskal_spanning_tree
// Loads random and directed graphs, predicts the spanning tree edges, and compares
// every tree word against the prediction; random stalls are on until the full-rate test.
// ----------------------------------------------------------------------------
module tb_kruskal_spanning_tree;
	import kst_pkg::*;

	localparam int QUIET_LIMIT = 300000;
	localparam int HOLD_CYCLES = 1500;

	typedef struct {
		logic [VERTEX_BITS-1:0]        from_v;
		logic [VERTEX_BITS-1:0]        to_v;
		logic signed [WEIGHT_BITS-1:0] weight;
		logic                          last;
		logic                          ovf;
	} tree_word_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [VERTEX_BITS-1:0] cfg_wdata;

	kst_edge_if edge_ch ();
	kst_tree_if tree_ch ();

	kruskal_spanning_tree uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.edge_in(edge_ch.sink), .tree_out(tree_ch.source)
	);

	// predictor state
	edge_t graph_edges[$];
	logic  graph_ovf;
	int    vcount_model;
	int    uf_parent[0:MAX_VERTICES];
	tree_word_t tree_expected[$];

	int errors;
	int words_seen;
	int edges_sent;
	int idle_cycles;
	bit idle_on;
	bit hold_rx;
	bit finished;
	event hold_start;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch %0s: got %0d expected %0d (word %0d)", what, got, want, words_seen);
		errors++;
	endtask

	function automatic int uf_find(int v);
		int r;
		int nx;
		r = v;
		while (uf_parent[r] != r) r = uf_parent[r];
		while (uf_parent[v] != r) begin
			nx = uf_parent[v];
			uf_parent[v] = r;
			v = nx;
		end
		return r;
	endfunction

	function automatic bit edge_before(edge_t a, edge_t b);
		if (a.weight != b.weight) return a.weight < b.weight;
		if (a.from_v != b.from_v) return a.from_v < b.from_v;
		return a.to_v < b.to_v;
	endfunction

	// sort stored edges and predict the tree words of one run
	task automatic predict_tree();
		edge_t key;
		int j;
		int nv;
		int accepted;
		int ra;
		int rb;
		tree_word_t w;
		for (int i = 1; i < graph_edges.size(); i++) begin
			key = graph_edges[i];
			j = i;
			while (j > 0 && edge_before(key, graph_edges[j-1])) begin
				graph_edges[j] = graph_edges[j-1];
				j--;
			end
			graph_edges[j] = key;
		end
		nv = vcount_model;
		if (nv == 0) nv = 1;
		if (nv > MAX_VERTICES) nv = MAX_VERTICES;
		for (int i = 0; i <= MAX_VERTICES; i++) uf_parent[i] = i;
		accepted = 0;
		for (int i = 0; i < graph_edges.size() && accepted + 1 < nv; i++) begin
			key = graph_edges[i];
			if (key.from_v < 1 || key.from_v > nv || key.to_v < 1 || key.to_v > nv)
				continue;
			ra = uf_find(key.from_v);
			rb = uf_find(key.to_v);
			if (ra == rb) continue;
			uf_parent[ra] = rb;
			w.from_v = key.from_v;
			w.to_v = key.to_v;
			w.weight = key.weight;
			w.last = 0;
			w.ovf = graph_ovf;
			tree_expected.insert(tree_expected.size(), w);
			accepted++;
		end
		if (accepted > 0) tree_expected[tree_expected.size()-1].last = 1;
		graph_edges.delete();
		graph_ovf = 0;
	endtask

	task automatic send_edge(input int f, input int t, input int wt, input bit last);
		edge_t e;
		bit gap;
		gap = idle_on && ($urandom_range(0, 5) == 0);
		if (gap || (idle_on && idle_cycles > 0)) edge_ch.valid <= 0;
		while (idle_on && idle_cycles > 0) @(posedge clk);
		if (gap) begin
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		edge_ch.valid <= 1;
		edge_ch.edge_from <= f[VERTEX_BITS-1:0];
		edge_ch.edge_to <= t[VERTEX_BITS-1:0];
		edge_ch.edge_weight <= wt[WEIGHT_BITS-1:0];
		edge_ch.edge_last <= last;
		@(posedge clk);
		while (!edge_ch.ready) @(posedge clk);
		edges_sent++;
		e.from_v = f[VERTEX_BITS-1:0];
		e.to_v = t[VERTEX_BITS-1:0];
		e.weight = wt[WEIGHT_BITS-1:0];
		if (graph_edges.size() < MAX_EDGES) graph_edges.insert(graph_edges.size(), e);
		else graph_ovf = 1;
		if (last) predict_tree();
	endtask

	task automatic drain();
		edge_ch.valid <= 0;
		while (tree_expected.size() > 0) @(posedge clk);
		// a run may still be busy with no word left; wait until loading again
		repeat (2) @(posedge clk);
		while (!edge_ch.ready) @(posedge clk);
	endtask

	task automatic set_vertices(input int n);
		drain();
		cfg_we <= 1;
		cfg_wdata <= n[VERTEX_BITS-1:0];
		@(posedge clk);
		cfg_we <= 0;
		vcount_model = n & 8'h7f;
	endtask

	task automatic random_graph(input int n_edges, input int vmax, input bit noise);
		int f;
		int t;
		for (int i = 0; i < n_edges; i++) begin
			f = $urandom_range(1, vmax);
			t = $urandom_range(1, vmax);
			if (noise && $urandom_range(0, 7) == 0) f = $urandom_range(0, 127);
			if (noise && $urandom_range(0, 7) == 0) t = $urandom_range(0, 127);
			send_edge(f, t, $urandom, i == n_edges - 1);
		end
	endtask

	task automatic test_directed();
		set_vertices(4);
		send_edge(1, 2, 16'h7fff, 0);
		send_edge(2, 3, 16'h8000, 0);
		send_edge(3, 3, 0, 0);
		send_edge(0, 1, -5, 0);
		send_edge(4, 5, -6, 0);
		send_edge(3, 4, 1, 0);
		send_edge(1, 4, 1, 0);
		send_edge(2, 1, 1, 1);
		// single edge, already last
		send_edge(127, 127, 16'hffff, 1);
		send_edge(1, 2, 3, 1);
		set_vertices(0);
		send_edge(1, 1, 7, 0);
		send_edge(1, 2, 7, 1);
		set_vertices(1);
		send_edge(1, 2, 7, 1);
		set_vertices(127);
		send_edge(64, 1, 2, 0);
		send_edge(63, 64, 2, 0);
		send_edge(65, 64, 2, 1);
	endtask

	task automatic test_overflow();
		set_vertices(64);
		random_graph(MAX_EDGES + 1, 64, 0);
	endtask

	task automatic test_random();
		int vm;
		for (int g = 0; g < 5; g++) begin
			vm = $urandom_range(2, 12);
			if (g % 5 == 4) vm = 64;
			set_vertices(g % 3 == 0 ? vm : $urandom_range(0, 127));
			random_graph($urandom_range(2, 6), vm, g % 2);
		end
	endtask

	task automatic test_backpressure();
		set_vertices(8);
		-> hold_start;
		random_graph(5, 8, 0);
		random_graph(4, 8, 0);
		drain();
		random_graph(3, 8, 0);
	endtask

	task automatic test_full_rate();
		idle_on = 0;
		set_vertices(6);
		random_graph(6, 6, 1);
	endtask

	// receiver
	always @(posedge clk) begin
		if (!arst_n) tree_ch.ready <= 0;
		else tree_ch.ready <= hold_rx ? 0 : (idle_on ? (idle_cycles == 0) : 1);
	end

	always @(posedge clk) begin
		if (idle_on && idle_cycles == 0 && $urandom_range(0, 9) == 0)
			idle_cycles <= $urandom_range(1, 11);
		else if (idle_cycles > 0)
			idle_cycles <= idle_cycles - 1;
	end

	// long receiver hold-off while edges keep coming
	initial begin
		forever begin
			@(hold_start);
			hold_rx = 1;
			repeat (HOLD_CYCLES) @(posedge clk);
			hold_rx = 0;
		end
	end

	tree_word_t want;
	always @(posedge clk) begin
		if (arst_n && tree_ch.valid && tree_ch.ready) begin
			words_seen++;
			if (tree_expected.size() == 0) begin
				report_mismatch("unexpected word from", tree_ch.tree_from, 0);
			end else begin
				want = tree_expected.pop_front();
				if (tree_ch.tree_from !== want.from_v)
					report_mismatch("tree_from", tree_ch.tree_from, want.from_v);
				if (tree_ch.tree_to !== want.to_v)
					report_mismatch("tree_to", tree_ch.tree_to, want.to_v);
				if (tree_ch.tree_weight !== want.weight)
					report_mismatch("tree_weight", tree_ch.tree_weight, want.weight);
				if (tree_ch.tree_last !== want.last)
					report_mismatch("tree_last", tree_ch.tree_last, want.last);
				if (tree_ch.edges_overflow !== want.ovf)
					report_mismatch("edges_overflow", tree_ch.edges_overflow, want.ovf);
			end
		end
	end

	// watchdog on cycles without any accepted word
	int quiet;
	always @(posedge clk) begin
		if ((edge_ch.valid && edge_ch.ready) || (tree_ch.valid && tree_ch.ready) || cfg_we)
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet > QUIET_LIMIT && !finished) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		edges_sent = 0;
		idle_on = 1;
		finished = 0;
		graph_ovf = 0;
		vcount_model = 64;
		arst_n = 0;
		cfg_we = 0;
		cfg_wdata = 0;
		edge_ch.valid = 0;
		edge_ch.edge_from = 0;
		edge_ch.edge_to = 0;
		edge_ch.edge_weight = 0;
		edge_ch.edge_last = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		test_random();
		test_backpressure();
		test_full_rate();
		test_overflow();
		drain();
		finished = 1;
		$display("sent %0d edges, checked %0d tree words", edges_sent, words_seen);
		$display("covered extreme weights, bad endpoints, loops, vertex limits, overflow, stalls");
		if (errors == 0 && tree_expected.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule
